// File: rtl/core/bfcd_pkg.sv
// Shared constants, types and the bytewise CRC32 update for the frame deframer.
`default_nettype none

package bfcd_pkg;

  localparam int COUNT_W = 17;
  localparam int HEADER_BYTES = 24;
  localparam int CRC_BYTES = 4;

  localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = COUNT_W'(1024);

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h44;
  localparam logic [7:0] SYNC_C = 8'hB5;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [COUNT_W-1:0] POS_ID_LO = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] POS_ID_HI = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] POS_LEN_LO = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] POS_LEN_HI = COUNT_W'(7);

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [1:0] CRC_LAST_BYTE = 2'd3;

  typedef enum logic [5:0] {
    PH_HUNT0   = 6'b000001,
    PH_HUNT1   = 6'b000010,
    PH_HUNT2   = 6'b000100,
    PH_HEADER  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CRC     = 6'b100000
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bfcd_byte_if.sv
// Received byte channel: valid/ready handshake with one byte per transfer.
`default_nettype none

interface bfcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bfcd_result_if.sv
// Frame result channel: valid/ready handshake carrying status, id and length.
`default_nettype none

interface bfcd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [15:0] message_id;
  logic [15:0] payload_length;

  modport source (output valid, output frame_status, output message_id,
                  output payload_length, input ready);
  modport sink (input valid, input frame_status, input message_id,
                input payload_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/binary_frame_crc_deframer_top.sv
// Byte-serial deframer: sync hunt, header capture, CRC32 check, frame result output.
// A result is registered: valid in the cycle after the frame's last byte is taken (last header byte if too long).
// Throughput: one byte per cycle unless a held result stalls input; the output register frees its slot while it drains.
// The bytewise CRC update and the phase logic fit between input and result registers.
// Reset (rst, synchronous): hunting for the first sync byte, counters and CRC cleared,
// max_frame_bytes back to 1024, no result pending.
`default_nettype none

module binary_frame_crc_deframer_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bfcd_byte_if.sink                         rx,
  bfcd_result_if.source                     res,
  input  wire logic                         cfg_we,
  input  wire logic [bfcd_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int CW = bfcd_pkg::COUNT_W;

  logic [CW-1:0]     max_frame_bytes;
  bfcd_pkg::phase_t  phase, phase_next;
  logic [CW-1:0]     byte_count, byte_count_next;
  logic [15:0]       held_id, held_id_next;
  logic [15:0]       held_length, held_length_next;
  logic [31:0]       running_crc, running_crc_next;
  logic [31:0]       received_crc, received_crc_next;

  logic              res_valid;
  logic [1:0]        res_status;
  logic [15:0]       res_id;
  logic [15:0]       res_length;

  logic              rx_fire;
  logic              load;
  logic [1:0]        status_next;

  assign rx.ready = !res_valid || res.ready;
  assign rx_fire  = rx.valid && rx.ready;

  assign res.valid          = res_valid;
  assign res.frame_status   = res_status;
  assign res.message_id     = res_id;
  assign res.payload_length = res_length;

  always_comb begin
    logic [7:0]    b;
    logic [31:0]   crc_upd;
    logic [CW-1:0] count_inc;
    logic [CW:0]   total;
    logic [CW-1:0] body_end;
    logic [1:0]    k;
    b                 = rx.rx_byte;
    crc_upd           = bfcd_pkg::crc_byte(running_crc, b);
    count_inc         = byte_count + CW'(1);
    total             = (CW+1)'(bfcd_pkg::HEADER_BYTES + bfcd_pkg::CRC_BYTES)
                        + {2'b00, held_length};
    body_end          = CW'(bfcd_pkg::HEADER_BYTES) + {1'b0, held_length};
    k                 = byte_count[1:0] - body_end[1:0];
    phase_next        = phase;
    byte_count_next   = byte_count;
    held_id_next      = held_id;
    held_length_next  = held_length;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    load              = 1'b0;
    status_next       = bfcd_pkg::ST_GOOD;

    if (rx_fire) begin
      case (phase)
        bfcd_pkg::PH_HUNT0: begin
          if (b == bfcd_pkg::SYNC_A) begin
            running_crc_next  = bfcd_pkg::crc_byte(32'h0, bfcd_pkg::SYNC_A);
            byte_count_next   = CW'(1);
            received_crc_next = 32'h0;
            phase_next        = bfcd_pkg::PH_HUNT1;
          end
        end
        bfcd_pkg::PH_HUNT1, bfcd_pkg::PH_HUNT2: begin
          if (phase == bfcd_pkg::PH_HUNT1 && b == bfcd_pkg::SYNC_B) begin
            running_crc_next = crc_upd;
            byte_count_next  = CW'(2);
            phase_next       = bfcd_pkg::PH_HUNT2;
          end else if (phase == bfcd_pkg::PH_HUNT2 && b == bfcd_pkg::SYNC_C) begin
            running_crc_next = crc_upd;
            byte_count_next  = CW'(3);
            phase_next       = bfcd_pkg::PH_HEADER;
          end else if (b == bfcd_pkg::SYNC_A) begin
            running_crc_next  = bfcd_pkg::crc_byte(32'h0, bfcd_pkg::SYNC_A);
            byte_count_next   = CW'(1);
            received_crc_next = 32'h0;
            phase_next        = bfcd_pkg::PH_HUNT1;
          end else begin
            phase_next = bfcd_pkg::PH_HUNT0;
          end
        end
        bfcd_pkg::PH_HEADER: begin
          running_crc_next = crc_upd;
          if (byte_count == bfcd_pkg::POS_ID_LO) begin
            held_id_next = {8'h00, b};
          end else if (byte_count == bfcd_pkg::POS_ID_HI) begin
            held_id_next = {b, held_id[7:0]};
          end else if (byte_count == bfcd_pkg::POS_LEN_LO) begin
            held_length_next = {8'h00, b};
          end else if (byte_count == bfcd_pkg::POS_LEN_HI) begin
            held_length_next = {b, held_length[7:0]};
          end
          byte_count_next = count_inc;
          total = (CW+1)'(bfcd_pkg::HEADER_BYTES + bfcd_pkg::CRC_BYTES)
                  + {2'b00, held_length_next};
          if (count_inc >= CW'(bfcd_pkg::HEADER_BYTES)) begin
            if (total > {1'b0, max_frame_bytes}) begin
              load            = 1'b1;
              status_next     = bfcd_pkg::ST_TOO_LONG;
              phase_next      = bfcd_pkg::PH_HUNT0;
              byte_count_next = '0;
            end else if (held_length_next == 16'h0) begin
              phase_next = bfcd_pkg::PH_CRC;
            end else begin
              phase_next = bfcd_pkg::PH_PAYLOAD;
            end
          end
        end
        bfcd_pkg::PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          byte_count_next  = count_inc;
          if (count_inc >= body_end) begin
            phase_next = bfcd_pkg::PH_CRC;
          end
        end
        bfcd_pkg::PH_CRC: begin
          received_crc_next = received_crc | ({24'h0, b} << {k, 3'b000});
          byte_count_next   = count_inc;
          if (k == bfcd_pkg::CRC_LAST_BYTE) begin
            load            = 1'b1;
            status_next     = (received_crc_next == running_crc) ? bfcd_pkg::ST_GOOD
                                                                  : bfcd_pkg::ST_CRC_ERR;
            phase_next      = bfcd_pkg::PH_HUNT0;
            byte_count_next = '0;
          end
        end
        default: begin
          phase_next      = bfcd_pkg::PH_HUNT0;
          byte_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= bfcd_pkg::MAX_FRAME_RESET;
      phase           <= bfcd_pkg::PH_HUNT0;
      byte_count      <= '0;
      held_id         <= '0;
      held_length     <= '0;
      running_crc     <= '0;
      received_crc    <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_frame_bytes <= cfg_wdata;
      end
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= status_next;
      res_id     <= held_id_next;
      res_length <= held_length_next;
    end
  end

  a_new_result_from_frame_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |->
      ($past(phase) == bfcd_pkg::PH_HEADER || $past(phase) == bfcd_pkg::PH_CRC))
    else $error("result raised outside header end or crc end");

  a_full_output_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !rx.ready)
    else $error("byte taken while result slot is full");

  a_payload_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == bfcd_pkg::PH_PAYLOAD) |-> (held_length != 16'h0))
    else $error("payload phase with zero length");

  a_header_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == bfcd_pkg::PH_HEADER) |->
      (byte_count >= CW'(3) && byte_count < CW'(bfcd_pkg::HEADER_BYTES)))
    else $error("header byte count out of range");

  a_status_code_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == bfcd_pkg::ST_GOOD || res_status == bfcd_pkg::ST_CRC_ERR
                   || res_status == bfcd_pkg::ST_TOO_LONG))
    else $error("undefined frame status");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for the binary frame CRC deframer: frame and noise stimulus, predictor, checks.
`default_nettype none

module tb_top;
  import bfcd_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [15:0] plen;
  } frame_report_t;

  class frame_tracker;
    phase_t              phase;
    logic [COUNT_W-1:0]  nbytes;
    logic [15:0]         id_acc;
    logic [15:0]         len_acc;
    logic [31:0]         crc_acc;
    logic [31:0]         crc_got;
    logic [COUNT_W-1:0]  limit;
    frame_report_t       frames_due[$];
    int                  bytes_taken;
    int                  frames_predicted;
    int                  errors;

    function new();
      phase = PH_HUNT0;
      nbytes = '0;
      id_acc = '0;
      len_acc = '0;
      crc_acc = '0;
      crc_got = '0;
      limit = MAX_FRAME_RESET;
      bytes_taken = 0;
      frames_predicted = 0;
      errors = 0;
    endfunction

    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
        r = {1'b0, r[31:1]} ^ ((r[0] ^ d[k]) ? CRC_POLY : 32'h0);
      end
      return r;
    endfunction

    task report(string what);
      errors++;
      $display("[tb] mismatch: %s", what);
    endtask

    function void open_frame();
      crc_acc = crc_next(32'h0, SYNC_A);
      nbytes = COUNT_W'(1);
      crc_got = '0;
      phase = PH_HUNT1;
    endfunction

    function void close_frame(logic [1:0] st);
      frame_report_t r;
      r.status = st;
      r.id = id_acc;
      r.plen = len_acc;
      frames_due.push_back(r);
      frames_predicted++;
      phase = PH_HUNT0;
      nbytes = '0;
    endfunction

    function void take_byte(logic [7:0] b);
      int k;
      bytes_taken++;
      case (phase)
        PH_HUNT0: begin
          if (b == SYNC_A) open_frame();
        end
        PH_HUNT1: begin
          if (b == SYNC_B) begin
            crc_acc = crc_next(crc_acc, b);
            nbytes = COUNT_W'(2);
            phase = PH_HUNT2;
          end else if (b == SYNC_A) begin
            open_frame();
          end else begin
            phase = PH_HUNT0;
          end
        end
        PH_HUNT2: begin
          if (b == SYNC_C) begin
            crc_acc = crc_next(crc_acc, b);
            nbytes = COUNT_W'(3);
            phase = PH_HEADER;
          end else if (b == SYNC_A) begin
            open_frame();
          end else begin
            phase = PH_HUNT0;
          end
        end
        PH_HEADER: begin
          crc_acc = crc_next(crc_acc, b);
          if (nbytes == POS_ID_LO) id_acc = {8'h00, b};
          else if (nbytes == POS_ID_HI) id_acc[15:8] = b;
          else if (nbytes == POS_LEN_LO) len_acc = {8'h00, b};
          else if (nbytes == POS_LEN_HI) len_acc[15:8] = b;
          nbytes = nbytes + COUNT_W'(1);
          if (int'(nbytes) >= HEADER_BYTES) begin
            if (HEADER_BYTES + int'(len_acc) + CRC_BYTES > int'(limit)) begin
              close_frame(ST_TOO_LONG);
            end else begin
              phase = (len_acc == 16'h0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_acc = crc_next(crc_acc, b);
          nbytes = nbytes + COUNT_W'(1);
          if (int'(nbytes) >= HEADER_BYTES + int'(len_acc)) phase = PH_CRC;
        end
        PH_CRC: begin
          k = (int'(nbytes) - (HEADER_BYTES + int'(len_acc))) & 3;
          crc_got = crc_got | (32'(b) << (8 * k));
          nbytes = nbytes + COUNT_W'(1);
          if (k == int'(CRC_LAST_BYTE)) close_frame((crc_got == crc_acc) ? ST_GOOD : ST_CRC_ERR);
        end
        default: begin
          phase = PH_HUNT0;
          nbytes = '0;
        end
      endcase
    endfunction

    task check_frame(logic [1:0] st, logic [15:0] id, logic [15:0] plen);
      frame_report_t want;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected result status %0d id %h len %0d", st, id, plen));
        return;
      end
      want = frames_due.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d (id %h)", st, want.status, want.id));
      if (id !== want.id)
        report($sformatf("message_id %h, want %h", id, want.id));
      if (plen !== want.plen)
        report($sformatf("payload_length %0d, want %0d (id %h)", plen, want.plen, want.id));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_left;
  bit                 hold_req;
  frame_tracker       sb = new();

  bfcd_byte_if   rx();
  bfcd_result_if res();

  binary_frame_crc_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    res.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_frame(res.frame_status, res.message_id, res.payload_length);
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    sb.take_byte(b);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(3))
        0:       b = SYNC_A;
        1:       b = SYNC_B;
        2:       b = SYNC_C;
        default: b = 8'($urandom);
      endcase
      if (sb.phase == PH_HUNT2 && b == SYNC_C) b = ~SYNC_C;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input bit corrupt);
    logic [7:0]  fb[$];
    logic [31:0] crc;
    fb = {SYNC_A, SYNC_B, SYNC_C, 8'($urandom), id[7:0], id[15:8], len[7:0], len[15:8]};
    while (fb.size() < HEADER_BYTES) fb.push_back(8'($urandom));
    if (HEADER_BYTES + int'(len) + CRC_BYTES > int'(sb.limit)) begin
      foreach (fb[i]) send_byte(fb[i]);
      send_noise($urandom_range(0, 6));
    end else begin
      repeat (len) fb.push_back(8'($urandom));
      crc = '0;
      foreach (fb[i]) crc = frame_tracker::crc_next(crc, fb[i]);
      if (corrupt) crc = crc ^ (32'h1 << $urandom_range(31));
      for (int i = 0; i < CRC_BYTES; i++) fb.push_back(crc[8*i +: 8]);
      foreach (fb[i]) send_byte(fb[i]);
    end
  endtask

  task automatic set_limit(input logic [COUNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.limit = v;
  endtask

  task automatic settle();
    while (sb.phase != PH_HUNT0) send_byte(8'h00);
    rx.valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(input int min_bytes, input int min_frames);
    int          b0;
    int          f0;
    int          sel;
    int          lim;
    logic [15:0] len;
    b0 = sb.bytes_taken;
    f0 = sb.frames_predicted;
    while (sb.bytes_taken - b0 < min_bytes || sb.frames_predicted - f0 < min_frames) begin
      lim = int'(sb.limit);
      if ($urandom_range(99) < 20) begin
        send_noise($urandom_range(1, 12));
      end else begin
        sel = $urandom_range(9);
        if (sel == 0) len = '0;
        else if (sel == 8 && lim >= 28 && lim - 28 <= 300) len = 16'(lim - 28);
        else if (sel == 9 && lim < 28) len = 16'($urandom);
        else if (sel == 9 && lim - 27 <= 65535) len = 16'(lim - 27);
        else len = 16'($urandom_range(1, 40));
        send_frame(16'($urandom), len, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    logic [7:0]         broken[$];
    logic [COUNT_W-1:0] seg_limit[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    hold_req = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 52;
    seg_limit[0] = COUNT_W'(28);
    seg_limit[1] = '0;
    seg_limit[2] = COUNT_W'(65563);
    seg_limit[3] = '1;
    seg_limit[4] = COUNT_W'(27);
    seg_limit[5] = COUNT_W'($urandom_range(29, 300));
    broken = {SYNC_A, SYNC_B, 8'h00, SYNC_A, SYNC_A, SYNC_B, SYNC_A, SYNC_B,
              SYNC_B, SYNC_C, SYNC_A, 8'hFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_limit(MAX_FRAME_RESET);
    foreach (broken[i]) send_byte(broken[i]);
    send_frame(16'h0000, 16'd0, 1'b0);
    send_frame(16'hFFFF, 16'd5, 1'b0);
    send_frame(16'h1234, 16'd3, 1'b1);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0);
    send_byte(SYNC_A);
    send_frame(16'h00FF, 16'd0, 1'b1);
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 52;
        recv_idle_pct = 22;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_limit(seg_limit[seg]);
      if (seg == 5) begin
        hold_req = 1'b1;
        repeat (6) send_frame(16'($urandom), 16'($urandom_range(0, 1)), 1'b0);
      end
      run_random(100, 3);
      settle();
    end

    if (sb.errors == 0) begin
      $display("[binary_frame_crc_deframer_top] OK");
    end else begin
      $display("[binary_frame_crc_deframer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[binary_frame_crc_deframer_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
